// ----- src/pmht_pkg.sv -----
// ----------------------------------------------------------------------------
// pmht_pkg
// Shared widths, codes and defaults of the pair matching hash table.
// ----------------------------------------------------------------------------
package pmht_pkg;

	// Fixed field widths of the channels
	localparam int KEY_W     = 31;
	localparam int IN_TAG_W  = 16;
	localparam int OUT_TAG_W = 16;
	localparam int STATUS_W  = 2;
	localparam int CFG_W     = 11;

	// Parameter defaults
	localparam int DEF_MAX_BUCKETS = 1024;
	localparam int DEF_SLOTS       = 8;
	localparam int DEF_TAG_BITS    = 16;

	// Bucket count after reset
	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1024);

	// Hash 77*key + 2222 stays below 2^38; round up to whole digits
	localparam int DIGIT_W = 4;
	localparam int HASH_W  = 40;
	localparam int NDIG    = HASH_W / DIGIT_W;
	localparam logic [HASH_W-1:0] HASH_MUL = HASH_W'(77);
	localparam logic [HASH_W-1:0] HASH_ADD = HASH_W'(2222);

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_MATCHED  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd3;

endpackage

// ----- src/pmht_if.sv -----
// ----------------------------------------------------------------------------
// pmht channel interfaces
// Valid/ready channels for requests, results and the bucket count register.
// ----------------------------------------------------------------------------
interface pmht_req_if;
	logic                          valid;
	logic                          ready;
	logic [pmht_pkg::KEY_W-1:0]    key;
	logic [pmht_pkg::IN_TAG_W-1:0] tag;
	modport source (output valid, key, tag, input ready);
	modport sink   (input valid, key, tag, output ready);
endinterface

interface pmht_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [pmht_pkg::STATUS_W-1:0]  status;
	logic [pmht_pkg::OUT_TAG_W-1:0] partner_tag;
	modport source (output valid, status, partner_tag, input ready);
	modport sink   (input valid, status, partner_tag, output ready);
endinterface

interface pmht_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [pmht_pkg::CFG_W-1:0] bucket_count;
	modport source (output valid, bucket_count, input ready);
	modport sink   (input valid, bucket_count, output ready);
endinterface

// ----- src/pair_matching_hash_table.sv -----
// ----------------------------------------------------------------------------
// pair_matching_hash_table
// Bucketed hash table that removes a key already present and inserts it
// otherwise, returning the stored partner tag on a match.
// ----------------------------------------------------------------------------
// Usage:
//   req  (sink)   : one request carries key and tag; taken when valid and
//                   ready are both high. ready is high only while idle.
//   rsp  (source) : one result per request, status and partner_tag.
//   cfg  (sink)   : bucket_count write, always ready; write it only while
//                   no request is in flight.
// Flow: a nonzero key passes from acceptance through the 4-bit
//   digit-serial remainder unit on 77*key+2222, the bucket row read and
//   evaluation with write-back into the registered result. A zero key skips
//   the remainder and the row read and goes straight to evaluation. Requests
//   are taken one at a time: the next is taken only once the result of the
//   last one is registered.
// Reset: the key memory is swept to zero, one bucket row a cycle, over all
//   MAX_BUCKETS rows (1024 by default); requests wait meanwhile, config
//   writes are taken. The tag memory is never cleared.
// Stall: the result register holds while rsp.ready is low; a new request
//   is still taken and worked on, and waits at evaluation until the
//   register frees.
// ----------------------------------------------------------------------------
module pair_matching_hash_table #(
	parameter int MAX_BUCKETS = pmht_pkg::DEF_MAX_BUCKETS,
	parameter int SLOTS       = pmht_pkg::DEF_SLOTS,
	parameter int TAG_BITS    = pmht_pkg::DEF_TAG_BITS
) (
	input  logic   clk,
	input  logic   arst_n,
	pmht_cfg_if.sink   cfg,
	pmht_req_if.sink   req,
	pmht_rsp_if.source rsp
);
	import pmht_pkg::*;

	// Modulus width, bucket address width, stored tag width
	localparam int NW = $clog2(MAX_BUCKETS + 1);
	localparam int AW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
	localparam int SW = (TAG_BITS < IN_TAG_W) ? TAG_BITS : IN_TAG_W;

	// Sequencer states
	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_HASH  = 2'd2;
	localparam logic [1:0] S_EVAL  = 2'd3;

	typedef logic [SLOTS-1:0][KEY_W-1:0] krow_t;
	typedef logic [SLOTS-1:0][SW-1:0]    trow_t;

	// Bucket rows: keys are swept clear after reset, tags are not
	krow_t key_mem [MAX_BUCKETS];
	trow_t tag_mem [MAX_BUCKETS];

	logic [1:0]        state_q;
	logic [AW-1:0]     clr_q;
	logic [CFG_W-1:0]  bucket_count_q;
	logic [KEY_W-1:0]  key_q;
	logic [SW-1:0]     tag_q;
	logic [AW-1:0]     bucket_q;
	krow_t             krow_q;
	trow_t             trow_q;
	logic              out_valid_q;
	logic [STATUS_W-1:0]  status_q;
	logic [OUT_TAG_W-1:0] partner_q;

	logic              req_fire;
	logic              eval_fire;
	logic [NW-1:0]     n_eff;
	logic [HASH_W-1:0] hash_val;
	logic              mod_done;
	logic [NW-1:0]     mod_rem;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;

	logic              hit_any;
	logic              emp_any;
	logic [SLOTS-1:0]  hit_oh;
	logic [SLOTS-1:0]  emp_oh;
	logic [OUT_TAG_W-1:0] partner_sel;
	logic [STATUS_W-1:0]  res_status;
	logic [OUT_TAG_W-1:0] res_partner;
	krow_t             krow_new;
	trow_t             trow_new;
	logic              row_upd;

	logic              kwr_en;
	logic [AW-1:0]     kwr_addr;
	krow_t             kwr_data;

	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	// Effective modulus: zero counts as one bucket, saturate at MAX_BUCKETS
	always_comb begin
		if (bucket_count_q == '0) begin
			n_eff = NW'(1);
		end else if (32'(bucket_count_q) > 32'(MAX_BUCKETS)) begin
			n_eff = NW'(MAX_BUCKETS);
		end else begin
			n_eff = NW'(bucket_count_q);
		end
	end

	assign hash_val = HASH_W'(req.key) * HASH_MUL + HASH_ADD;

	// Start the remainder only for keys that will be looked up
	pmht_mod #(
		.NW (NW)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (req_fire && (req.key != '0)),
		.dividend (hash_val),
		.divisor  (n_eff),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// Issue the row read as soon as the bucket is known
	assign rd_en   = (state_q == S_HASH) && mod_done;
	assign rd_addr = AW'(mod_rem);

	// Evaluate the row: first matching slot, first empty slot
	always_comb begin
		hit_any     = 1'b0;
		emp_any     = 1'b0;
		hit_oh      = '0;
		emp_oh      = '0;
		partner_sel = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (!hit_any && (krow_q[i] == key_q)) begin
				hit_any     = 1'b1;
				hit_oh[i]   = 1'b1;
				partner_sel = OUT_TAG_W'(trow_q[i]);
			end
			if (!emp_any && (krow_q[i] == '0)) begin
				emp_any   = 1'b1;
				emp_oh[i] = 1'b1;
			end
		end
	end

	always_comb begin
		krow_new    = krow_q;
		trow_new    = trow_q;
		res_partner = '0;
		if (key_q == '0) begin
			res_status = ST_INVALID;
		end else if (hit_any) begin
			// Drop the matched entry and hand back its tag
			res_status  = ST_MATCHED;
			res_partner = partner_sel;
			for (int i = 0; i < SLOTS; i++) begin
				if (hit_oh[i]) begin
					krow_new[i] = '0;
				end
			end
		end else if (emp_any) begin
			res_status = ST_INSERTED;
			for (int i = 0; i < SLOTS; i++) begin
				if (emp_oh[i]) begin
					krow_new[i] = key_q;
					trow_new[i] = tag_q;
				end
			end
		end else begin
			res_status = ST_FULL;
		end
	end

	assign row_upd   = (res_status == ST_MATCHED) || (res_status == ST_INSERTED);
	assign eval_fire = (state_q == S_EVAL) && (!out_valid_q || rsp.ready);

	// Key memory write port: clearing sweep or write-back
	always_comb begin
		if (state_q == S_CLEAR) begin
			kwr_en   = 1'b1;
			kwr_addr = clr_q;
			kwr_data = '0;
		end else begin
			kwr_en   = eval_fire && row_upd;
			kwr_addr = bucket_q;
			kwr_data = krow_new;
		end
	end

	always_ff @(posedge clk) begin
		if (kwr_en) begin
			key_mem[kwr_addr] <= kwr_data;
		end
		if (eval_fire && row_upd) begin
			tag_mem[bucket_q] <= trow_new;
		end
		if (rd_en) begin
			krow_q <= key_mem[rd_addr];
			trow_q <= tag_mem[rd_addr];
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(MAX_BUCKETS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_fire) begin
						state_q <= (req.key == '0) ? S_EVAL : S_HASH;
					end
				end
				S_HASH: begin
					if (mod_done) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (eval_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Hold the request fields and the bucket for the write-back
	always_ff @(posedge clk) begin
		if (req_fire) begin
			key_q <= req.key;
			tag_q <= req.tag[SW-1:0];
		end
		if (rd_en) begin
			bucket_q <= rd_addr;
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= CFG_RESET;
		end else if (cfg.valid && cfg.ready) begin
			bucket_count_q <= cfg.bucket_count;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (eval_fire) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eval_fire) begin
			status_q  <= res_status;
			partner_q <= res_partner;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = status_q;
	assign rsp.partner_tag = partner_q;

endmodule

// ----- src/pmht_mod.sv -----
// ----------------------------------------------------------------------------
// pmht_mod
// Digit-serial remainder unit: one DIGIT_W-bit digit of the dividend a cycle.
// ----------------------------------------------------------------------------
module pmht_mod #(
	parameter int NW = 11
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [pmht_pkg::HASH_W-1:0] dividend,
	input  logic [NW-1:0]               divisor,
	output logic                        done,
	output logic [NW-1:0]               rem
);
	import pmht_pkg::*;

	localparam int CW = $clog2(NDIG);
	localparam int TW = NW + DIGIT_W;

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [HASH_W-1:0] dvd_q;
	logic [NW-1:0]     div_q;
	logic [NW-1:0]     rem_q;
	logic [NW-1:0]     rem_nxt;

	// Restoring reduction of {rem, digit} (below 2^DIGIT_W times the divisor)
	always_comb begin
		logic [TW-1:0] t;
		logic [TW-1:0] sub;
		t = {rem_q, dvd_q[HASH_W-1 -: DIGIT_W]};
		for (int j = DIGIT_W - 1; j >= 0; j--) begin
			sub = TW'(div_q) << j;
			if (t >= sub) begin
				t = t - sub;
			end
		end
		rem_nxt = t[NW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NDIG - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << DIGIT_W;
			rem_q <= rem_nxt;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule
